FILE: rtl/thread_ready_wait_queue_manager_unit_macros.svh
// assertion macros for the thread ready/wait queue manager
// no dependencies; included by the top level
`ifndef THREAD_READY_WAIT_QUEUE_MANAGER_UNIT_MACROS_SVH
`define THREAD_READY_WAIT_QUEUE_MANAGER_UNIT_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge out of reset
`define TRWQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// expression must never be true out of reset
`define TRWQ_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);
`else
`define TRWQ_ASSERT(label, clk, rst_n, prop, msg)
`define TRWQ_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

FILE: rtl/trwq_pkg.sv
// shared types and codes for the thread ready/wait queue manager
// no dependencies
`default_nettype none

package trwq_pkg;

  localparam int unsigned MaxThreadsDef = 16;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned IdW     = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ListW   = 2;
  localparam int unsigned CountW  = 5;

  // operation codes
  localparam logic [FuncW-1:0] FnCreate  = 3'd0;
  localparam logic [FuncW-1:0] FnPop     = 3'd1;
  localparam logic [FuncW-1:0] FnSuspend = 3'd2;
  localparam logic [FuncW-1:0] FnResume  = 3'd3;
  localparam logic [FuncW-1:0] FnCancel  = 3'd4;

  // status codes
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StNotFound = 2'd1;
  localparam logic [StatusW-1:0] StFull     = 2'd2;
  localparam logic [StatusW-1:0] StEmpty    = 2'd3;

  // list tags
  localparam logic [ListW-1:0] ListNone  = 2'd0;
  localparam logic [ListW-1:0] ListReady = 2'd1;
  localparam logic [ListW-1:0] ListWait  = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [IdW-1:0]   tid;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     out_thread;
    logic [ListW-1:0]   found_in;
    logic [CountW-1:0]  ready_count;
    logic [CountW-1:0]  waiting_count;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/thread_ready_wait_queue_manager_unit.sv
// top level of the thread ready/wait queue manager: slot rams, sequencer, result register
// depends on trwq_pkg, trwq_ram, trwq_ctrl and the unit's assertion macro header
`default_nettype none

// usage
// - command channel: a word on req_i (func, tid) is taken at a rising edge
//   with start high and busy low; busy stays high while the word is worked on
// - result channel: done_o is high for exactly one cycle with the result on rsp_o;
//   there is no back-pressure, the result must be taken in that cycle
// - one word is worked on at a time; how long it takes from accept to done_o depends on func:
//   pop on an empty ready list and an unknown func go straight to the result,
//   create scans from slot 0 up to the lowest free slot (all slots when full),
//   suspend/resume walk their list from the head up to the thread,
//   a suspend/resume miss walks the whole list,
//   cancel walks the ready list and then, when not found there, the wait list
// - the walks go one linked slot per cycle, since the next slot address comes out of the next-link
//   ram through its registered read port
// - busy drops in the cycle done_o is high, so the next word may be taken then
// - slot identifiers and links sit in three rams; list heads, tails, counts and the
//   per-slot occupied bits sit in flops
// - reset empties both lists at once (occupied bits cleared); no ram clearing pass
// - counts on rsp_o are the list sizes after the operation, truncated to 5 bits

`include "thread_ready_wait_queue_manager_unit_macros.svh"

module thread_ready_wait_queue_manager_unit #(
  parameter int unsigned MAX_THREADS = trwq_pkg::MaxThreadsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  trwq_pkg::req_t req_i,
  output logic           done_o,
  output trwq_pkg::rsp_t rsp_o
);

  import trwq_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_THREADS);

  // shared read address: identifier and both links of one slot come back together
  logic [IdxW-1:0] rd_addr;
  logic            thr_we, nxt_we, prv_we;
  logic [IdxW-1:0] thr_waddr, nxt_waddr, prv_waddr;
  logic [IdW-1:0]  thr_wdata, thr_rdata;
  logic [IdxW-1:0] nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;

  logic fin;
  rsp_t rsp;

  logic done_q;
  rsp_t rsp_q;

  trwq_ram #(
    .WIDTH (IdW),
    .DEPTH (MAX_THREADS)
  ) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (thr_we),
    .waddr_i (thr_waddr),
    .wdata_i (thr_wdata),
    .raddr_i (rd_addr),
    .rdata_o (thr_rdata)
  );

  // next links of each slot
  trwq_ram #(
    .WIDTH (IdxW),
    .DEPTH (MAX_THREADS)
  ) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (rd_addr),
    .rdata_o (nxt_rdata)
  );

  // previous links of each slot
  trwq_ram #(
    .WIDTH (IdxW),
    .DEPTH (MAX_THREADS)
  ) u_prv_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prv_rdata)
  );

  trwq_ctrl #(
    .MAX_THREADS (MAX_THREADS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .fin_o       (fin),
    .rsp_o       (rsp),
    .rd_addr_o   (rd_addr),
    .thr_we_o    (thr_we),
    .thr_waddr_o (thr_waddr),
    .thr_wdata_o (thr_wdata),
    .thr_rdata_i (thr_rdata),
    .nxt_we_o    (nxt_we),
    .nxt_waddr_o (nxt_waddr),
    .nxt_wdata_o (nxt_wdata),
    .nxt_rdata_i (nxt_rdata),
    .prv_we_o    (prv_we),
    .prv_waddr_o (prv_waddr),
    .prv_wdata_o (prv_wdata),
    .prv_rdata_i (prv_rdata)
  );

  // result register: strobe resets, payload does not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      rsp_q <= rsp;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // no result can follow an accepted word in the very next cycle
  `TRWQ_ASSERT(a_no_instant_done, clk_i, rst_ni, (start && !busy) |=> !done_o, "done right after accept")
  // an accepted word keeps the unit busy
  `TRWQ_ASSERT(a_busy_after_accept, clk_i, rst_ni, (start && !busy) |=> busy, "not busy after accept")
  // the result strobe comes only once the sequencer is idle again
  `TRWQ_ASSERT_NEVER(a_done_while_busy, clk_i, rst_ni, done_o && busy, "done while busy")
  // a failed operation names no thread and no list
  `TRWQ_ASSERT(a_fail_clean, clk_i, rst_ni, (done_o && rsp_o.status != StOk) |-> (rsp_o.out_thread == '0 && rsp_o.found_in == ListNone), "failed result not clean")
  // both lists together never hold more than the slot store
  `TRWQ_ASSERT(a_count_bound, clk_i, rst_ni, done_o |-> ((32'(rsp_o.ready_count) + 32'(rsp_o.waiting_count)) <= 32'(MAX_THREADS)), "list counts exceed slot store")

endmodule

`default_nettype wire

FILE: rtl/trwq_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module trwq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/trwq_ctrl.sv
// sequencer for the ready/wait lists: free slot scan, list walk, link updates
// depends on trwq_pkg; drives the slot rams held in the top level
`default_nettype none

module trwq_ctrl #(
  parameter int unsigned MAX_THREADS = trwq_pkg::MaxThreadsDef,
  localparam int unsigned IdxW = $clog2(MAX_THREADS),
  localparam int unsigned CntW = $clog2(MAX_THREADS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  trwq_pkg::req_t      req_i,
  output logic                busy_o,
  output logic                fin_o,
  output trwq_pkg::rsp_t      rsp_o,
  output logic [IdxW-1:0]     rd_addr_o,
  output logic                thr_we_o,
  output logic [IdxW-1:0]     thr_waddr_o,
  output logic [trwq_pkg::IdW-1:0] thr_wdata_o,
  input  logic [trwq_pkg::IdW-1:0] thr_rdata_i,
  output logic                nxt_we_o,
  output logic [IdxW-1:0]     nxt_waddr_o,
  output logic [IdxW-1:0]     nxt_wdata_o,
  input  logic [IdxW-1:0]     nxt_rdata_i,
  output logic                prv_we_o,
  output logic [IdxW-1:0]     prv_waddr_o,
  output logic [IdxW-1:0]     prv_wdata_o,
  input  logic [IdxW-1:0]     prv_rdata_i
);

  import trwq_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SScan   = 4'd1;
  localparam logic [3:0] SPop    = 4'd2;
  localparam logic [3:0] SSStart = 4'd3;
  localparam logic [3:0] SSrch   = 4'd4;
  localparam logic [3:0] SUnlink = 4'd5;
  localparam logic [3:0] SApp1   = 4'd6;
  localparam logic [3:0] SApp2   = 4'd7;
  localparam logic [3:0] SFin    = 4'd8;

  logic [3:0]             state_q, state_d;
  logic [IdxW-1:0]        rhead_q, rhead_d, rtail_q, rtail_d;
  logic [IdxW-1:0]        whead_q, whead_d, wtail_q, wtail_d;
  logic [CntW-1:0]        rtot_q, rtot_d, wtot_q, wtot_d;
  logic [MAX_THREADS-1:0] occ_q, occ_d;

  logic [FuncW-1:0]   func_q, func_d;
  logic [IdW-1:0]     id_q, id_d;
  logic [IdW-1:0]     who_q, who_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [ListW-1:0]   found_q, found_d;
  logic [ListW-1:0]   lst_q, lst_d;
  logic [ListW-1:0]   app_lst_q, app_lst_d;
  logic [IdxW-1:0]    cur_q, cur_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [IdxW-1:0]    s_q, s_d, snext_q, snext_d, sprev_q, sprev_d;

  // views of the list being searched and of the list being appended to
  logic [IdxW-1:0] sel_head, sel_tail, new_head, new_tail, app_tail;
  logic [CntW-1:0] sel_tot, new_tot, app_tot, cnt_inc;

  assign sel_head = (lst_q == ListReady) ? rhead_q : whead_q;
  assign sel_tail = (lst_q == ListReady) ? rtail_q : wtail_q;
  assign sel_tot  = (lst_q == ListReady) ? rtot_q  : wtot_q;
  assign app_tail = (app_lst_q == ListReady) ? rtail_q : wtail_q;
  assign app_tot  = (app_lst_q == ListReady) ? rtot_q  : wtot_q;
  assign cnt_inc  = cnt_q + CntW'(1);

  always_comb begin
    state_d   = state_q;
    rhead_d   = rhead_q;
    rtail_d   = rtail_q;
    whead_d   = whead_q;
    wtail_d   = wtail_q;
    rtot_d    = rtot_q;
    wtot_d    = wtot_q;
    occ_d     = occ_q;
    func_d    = func_q;
    id_d      = id_q;
    who_d     = who_q;
    status_d  = status_q;
    found_d   = found_q;
    lst_d     = lst_q;
    app_lst_d = app_lst_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    s_d       = s_q;
    snext_d   = snext_q;
    sprev_d   = sprev_q;
    new_head  = sel_head;
    new_tail  = sel_tail;
    new_tot   = sel_tot;

    rd_addr_o   = cur_q;
    thr_we_o    = 1'b0;
    thr_waddr_o = cur_q;
    thr_wdata_o = id_q;
    nxt_we_o    = 1'b0;
    nxt_waddr_o = s_q;
    nxt_wdata_o = '0;
    prv_we_o    = 1'b0;
    prv_waddr_o = s_q;
    prv_wdata_o = '0;

    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          func_d   = req_i.func;
          id_d     = req_i.tid;
          who_d    = req_i.tid;
          status_d = StNotFound;
          found_d  = ListNone;
          cnt_d    = '0;
          unique case (req_i.func) inside
            FnCreate: begin
              cur_d   = '0;
              state_d = SScan;
            end
            FnPop: begin
              lst_d = ListReady;
              if (rtot_q == '0) begin
                status_d = StEmpty;
                state_d  = SFin;
              end else begin
                rd_addr_o = rhead_q;
                cur_d     = rhead_q;
                state_d   = SPop;
              end
            end
            FnSuspend, FnCancel: begin
              lst_d   = ListReady;
              state_d = SSStart;
            end
            FnResume: begin
              lst_d   = ListWait;
              state_d = SSStart;
            end
            default: begin
              state_d = SFin;
            end
          endcase
        end
      end

      // lowest free slot, one slot per cycle
      SScan: begin
        if (!occ_q[cur_q]) begin
          s_d         = cur_q;
          thr_we_o    = 1'b1;
          thr_waddr_o = cur_q;
          app_lst_d   = ListReady;
          state_d     = SApp1;
        end else if (cur_q == IdxW'(MAX_THREADS - 1)) begin
          status_d = StFull;
          state_d  = SFin;
        end else begin
          cur_d = cur_q + IdxW'(1);
        end
      end

      SPop: begin
        s_d     = cur_q;
        snext_d = nxt_rdata_i;
        sprev_d = prv_rdata_i;
        who_d   = thr_rdata_i;
        found_d = ListReady;
        state_d = SUnlink;
      end

      SSStart: begin
        if (sel_tot == '0) begin
          if (func_q == FnCancel && lst_q == ListReady) begin
            lst_d = ListWait;
          end else begin
            state_d = SFin;
          end
        end else begin
          rd_addr_o = sel_head;
          cur_d     = sel_head;
          cnt_d     = '0;
          state_d   = SSrch;
        end
      end

      // one linked slot per cycle, next address straight from the ram
      SSrch: begin
        if (thr_rdata_i == id_q) begin
          s_d     = cur_q;
          snext_d = nxt_rdata_i;
          sprev_d = prv_rdata_i;
          found_d = lst_q;
          state_d = SUnlink;
        end else if (cnt_inc == sel_tot) begin
          if (func_q == FnCancel && lst_q == ListReady) begin
            lst_d   = ListWait;
            state_d = SSStart;
          end else begin
            state_d = SFin;
          end
        end else begin
          cur_d     = nxt_rdata_i;
          rd_addr_o = nxt_rdata_i;
          cnt_d     = cnt_inc;
        end
      end

      SUnlink: begin
        if (sel_tot == CntW'(1)) begin
          new_head = '0;
          new_tail = '0;
        end else if (s_q == sel_head) begin
          new_head = snext_q;
        end else if (s_q == sel_tail) begin
          new_tail = sprev_q;
        end else begin
          nxt_we_o    = 1'b1;
          nxt_waddr_o = sprev_q;
          nxt_wdata_o = snext_q;
          prv_we_o    = 1'b1;
          prv_waddr_o = snext_q;
          prv_wdata_o = sprev_q;
        end
        new_tot = sel_tot - CntW'(1);
        if (lst_q == ListReady) begin
          rhead_d = new_head;
          rtail_d = new_tail;
          rtot_d  = new_tot;
        end else begin
          whead_d = new_head;
          wtail_d = new_tail;
          wtot_d  = new_tot;
        end
        if (func_q == FnSuspend || func_q == FnResume) begin
          app_lst_d = (lst_q == ListReady) ? ListWait : ListReady;
          state_d   = SApp1;
        end else begin
          occ_d[s_q] = 1'b0;
          status_d   = StOk;
          state_d    = SFin;
        end
      end

      SApp1: begin
        nxt_we_o    = 1'b1;
        nxt_wdata_o = '0;
        prv_we_o    = 1'b1;
        prv_wdata_o = (app_tot == '0) ? '0 : app_tail;
        state_d     = SApp2;
      end

      SApp2: begin
        if (app_tot != '0) begin
          nxt_we_o    = 1'b1;
          nxt_waddr_o = app_tail;
          nxt_wdata_o = s_q;
        end
        if (app_lst_q == ListReady) begin
          if (app_tot == '0) begin
            rhead_d = s_q;
          end
          rtail_d = s_q;
          rtot_d  = rtot_q + CntW'(1);
        end else begin
          if (app_tot == '0) begin
            whead_d = s_q;
          end
          wtail_d = s_q;
          wtot_d  = wtot_q + CntW'(1);
        end
        occ_d[s_q] = 1'b1;
        status_d   = StOk;
        state_d    = SFin;
      end

      SFin: begin
        state_d = SIdle;
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rhead_q <= '0;
      rtail_q <= '0;
      whead_q <= '0;
      wtail_q <= '0;
      rtot_q  <= '0;
      wtot_q  <= '0;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      rhead_q <= rhead_d;
      rtail_q <= rtail_d;
      whead_q <= whead_d;
      wtail_q <= wtail_d;
      rtot_q  <= rtot_d;
      wtot_q  <= wtot_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    id_q      <= id_d;
    who_q     <= who_d;
    status_q  <= status_d;
    found_q   <= found_d;
    lst_q     <= lst_d;
    app_lst_q <= app_lst_d;
    cur_q     <= cur_d;
    cnt_q     <= cnt_d;
    s_q       <= s_d;
    snext_q   <= snext_d;
    sprev_q   <= sprev_d;
  end

  assign busy_o = (state_q != SIdle);
  assign fin_o  = (state_q == SFin);

  always_comb begin
    rsp_o.status        = status_q;
    rsp_o.out_thread    = (status_q == StOk) ? who_q : '0;
    rsp_o.found_in      = found_q;
    rsp_o.ready_count   = CountW'(rtot_q);
    rsp_o.waiting_count = CountW'(wtot_q);
  end

endmodule

`default_nettype wire
